// File: design/motor_slow_fault_qualifier_core_macros.svh
// Assertion macros shared by the checker of the slow-tick fault qualifier.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef MOTOR_SLOW_FAULT_QUALIFIER_CORE_MACROS_SVH
`define MOTOR_SLOW_FAULT_QUALIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSFQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msfq assertion failed");

// Next-cycle implication, disabled during reset.
`define MSFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msfq assertion failed");

`endif

// File: design/msfq_pkg.sv
// Package of the slow-tick motor fault qualifier: field widths, register
// indexes, reset values and fixed qualification constants. No dependencies.
package msfq_pkg;

   localparam int CUR_W     = 16;
   localparam int BUS_W     = 16;
   localparam int SPD_W     = 24;
   localparam int SEQ_W     = 32;
   localparam int DT_W      = 16;
   localparam int ACC_W     = 32;
   localparam int FAULT_W   = 4;
   localparam int MASK_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   // Fixed qualification constants.
   localparam logic [16:0]      UV_HYST_MV      = 17'd1000;
   localparam logic [ACC_W-1:0] COMM_TIMEOUT_MS = 32'd1000;

   // Register reset values.
   localparam logic [MASK_W-1:0] RST_ENABLE_MASK      = 4'd15;
   localparam logic [15:0]       RST_UV_LEVEL_MV      = 16'd9000;
   localparam logic [15:0]       RST_UV_TIME_MS       = 16'd500;
   localparam logic [15:0]       RST_STALL_CURRENT_MA = 16'd2400;
   localparam logic [23:0]       RST_STALL_SPEED_MRPS = 24'd500;
   localparam logic [15:0]       RST_STALL_TIME_MS    = 16'd2000;
   localparam logic [23:0]       RST_SPD_ERR_MRPS     = 24'd2000;
   localparam logic [15:0]       RST_SPD_ERR_TIME_MS  = 16'd2000;

   // Enable mask bits.
   localparam int EN_COMM  = 0;
   localparam int EN_UV    = 1;
   localparam int EN_STALL = 2;
   localparam int EN_SPD   = 3;

   // Fault bit positions.
   localparam int FB_UV    = 0;
   localparam int FB_COMM  = 1;
   localparam int FB_STALL = 2;
   localparam int FB_SPD   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE_MASK      = 3'd0,
      CSR_UV_LEVEL_MV      = 3'd1,
      CSR_UV_TIME_MS       = 3'd2,
      CSR_STALL_CURRENT_MA = 3'd3,
      CSR_STALL_SPEED_MRPS = 3'd4,
      CSR_STALL_TIME_MS    = 3'd5,
      CSR_SPD_ERR_MRPS     = 3'd6,
      CSR_SPD_ERR_TIME_MS  = 3'd7
   } csr_index_type;

endpackage

// File: design/msfq_req_if.sv
// Sample channel of the slow-tick fault qualifier: valid/ready and one sample.
// Depends on msfq_pkg for field widths.
interface msfq_req_if;
   import msfq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [CUR_W-1:0] current_a;
   logic signed [CUR_W-1:0] current_b;
   logic signed [CUR_W-1:0] current_c;
   logic [BUS_W-1:0]        bus_mv;
   logic signed [SPD_W-1:0] speed_mrps;
   logic signed [SPD_W-1:0] target_mrps;
   logic [SEQ_W-1:0]        rx_seq;
   logic                    is_run;
   logic [DT_W-1:0]         delta_ms;
   logic                    sample_invalid;

   modport source (
      output valid, current_a, current_b, current_c, bus_mv, speed_mrps,
             target_mrps, rx_seq, is_run, delta_ms, sample_invalid,
      input  ready
   );
   modport sink (
      input  valid, current_a, current_b, current_c, bus_mv, speed_mrps,
             target_mrps, rx_seq, is_run, delta_ms, sample_invalid,
      output ready
   );
endinterface

// File: design/msfq_rsp_if.sv
// Result channel of the slow-tick fault qualifier: valid/ready and fault bits.
// Depends on msfq_pkg for the field width.
interface msfq_rsp_if;
   import msfq_pkg::*;

   logic               valid;
   logic               ready;
   logic [FAULT_W-1:0] fault_bits;

   modport source (output valid, fault_bits, input ready);
   modport sink (input valid, fault_bits, output ready);
endinterface

// File: design/motor_slow_fault_qualifier_core.sv
// Slow-tick motor fault qualifier, top level and only datapath module.
// Depends on msfq_pkg, msfq_req_if and msfq_rsp_if.
//
// Usage: each transaction on the req channel is one slow-tick sample. Every
// sample produces exactly one transaction on the rsp channel carrying four
// fault bits: undervoltage or invalid sample, communication timeout, stall and
// speed error. Thresholds live in eight registers written through the csr
// port (write enable, index, data); write them only while no sample is in
// flight.
// An accepted sample is held in the sample register, then in the result
// register, from which its result is taken. Throughput is one sample per
// cycle while the receiver does not stall; the accumulators are updated by
// the single compare and saturating-add pass that moves a sample from the
// sample register into the result register.
// When the receiver stalls, the result register holds its transaction and the
// sample register can still take one more sample; after that req ready drops
// until the result is taken. Synchronous reset clears both stages, all five
// accumulator/sequence registers and restores the register defaults; ready is
// low while reset is asserted.
module motor_slow_fault_qualifier_core (
   input  logic                                 clock,
   input  logic                                 reset,
   msfq_req_if.sink                             req_chan,
   msfq_rsp_if.source                           rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [msfq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msfq_pkg::CSR_DAT_W-1:0]       csr_data
);
   import msfq_pkg::*;

   // Configuration registers.
   logic [MASK_W-1:0] enable_mask_ff;
   logic [15:0]       uv_level_ff;
   logic [15:0]       uv_time_ff;
   logic [15:0]       stall_cur_ff;
   logic [23:0]       stall_spd_ff;
   logic [15:0]       stall_time_ff;
   logic [23:0]       spd_err_ff;
   logic [15:0]       spd_err_time_ff;

   // Sample register.
   logic                    s1_vld_ff;
   logic signed [CUR_W-1:0] s1_cur_a_ff, s1_cur_b_ff, s1_cur_c_ff;
   logic [BUS_W-1:0]        s1_bus_ff;
   logic signed [SPD_W-1:0] s1_speed_ff, s1_target_ff;
   logic [SEQ_W-1:0]        s1_seq_ff;
   logic                    s1_run_ff;
   logic [DT_W-1:0]         s1_dt_ff;
   logic                    s1_inv_ff;

   // Result register.
   logic               out_vld_ff;
   logic [FAULT_W-1:0] out_fault_ff;
   logic [FAULT_W-1:0] out_fault_in;

   // Accumulators.
   logic [ACC_W-1:0] comm_idle_ff, comm_idle_in;
   logic [SEQ_W-1:0] last_rx_ff, last_rx_in;
   logic [ACC_W-1:0] uv_acc_ff, uv_acc_in;
   logic [ACC_W-1:0] stall_acc_ff, stall_acc_in;
   logic [ACC_W-1:0] spd_acc_ff, spd_acc_in;

   logic out_free, s1_adv, req_fire;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [DT_W-1:0] dt);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + {{(ACC_W-DT_W+1){1'b0}}, dt};
      return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
   endfunction

   function automatic logic [CUR_W:0] cur_mag(input logic signed [CUR_W-1:0] x);
      logic [CUR_W:0] ext;
      ext = {x[CUR_W-1], x};
      return x[CUR_W-1] ? (~ext + 1'b1) : ext;
   endfunction

   // Handshake: the result register frees when empty or being taken, and the
   // sample register moves forward whenever the result register is free.
   assign out_free = !out_vld_ff || rsp_chan.ready;
   assign s1_adv   = s1_vld_ff && out_free;
   assign req_chan.ready = !reset && (!s1_vld_ff || out_free);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.fault_bits = out_fault_ff;

   // Derived magnitudes of the held sample.
   logic [CUR_W:0]        mag_a, mag_b, mag_c, mag_max;
   logic [SPD_W-1:0]      spd_mag;
   logic signed [SPD_W+1:0] dev;
   logic [SPD_W:0]        dev_mag;
   logic                  uv_below, uv_above, stall_cond, spd_cond, comm_active;

   always_comb begin
      mag_a = cur_mag(s1_cur_a_ff);
      mag_b = cur_mag(s1_cur_b_ff);
      mag_c = cur_mag(s1_cur_c_ff);
      mag_max = mag_a;
      if (mag_b > mag_max) begin
         mag_max = mag_b;
      end
      if (mag_c > mag_max) begin
         mag_max = mag_c;
      end
      // The speed magnitude is at most 2**(SPD_W-1), which
      // still fits the field width unsigned.
      spd_mag = s1_speed_ff[SPD_W-1] ? (~s1_speed_ff + 1'b1) : s1_speed_ff;
      dev = $signed({2'b00, spd_mag}) - $signed({{2{s1_target_ff[SPD_W-1]}}, s1_target_ff});
      dev_mag = dev[SPD_W+1] ? (~dev[SPD_W:0] + 1'b1) : dev[SPD_W:0];

      uv_below   = s1_bus_ff < uv_level_ff;
      uv_above   = {1'b0, s1_bus_ff} > ({1'b0, uv_level_ff} + UV_HYST_MV);
      stall_cond = (mag_max > {1'b0, stall_cur_ff}) && (spd_mag < stall_spd_ff);
      spd_cond   = dev_mag > {1'b0, spd_err_ff};
      comm_active = enable_mask_ff[EN_COMM] && s1_run_ff && (s1_seq_ff != '0);
   end

   // Next accumulator values and fault bits for the held sample.
   always_comb begin
      out_fault_in = '0;
      out_fault_in[FB_UV] = s1_inv_ff;

      comm_idle_in = '0;
      last_rx_in   = s1_seq_ff;
      if (comm_active && (s1_seq_ff == last_rx_ff)) begin
         comm_idle_in = sat_add(comm_idle_ff, s1_dt_ff);
         last_rx_in   = last_rx_ff;
      end
      if (comm_active && (comm_idle_in >= COMM_TIMEOUT_MS)) begin
         out_fault_in[FB_COMM] = 1'b1;
      end

      uv_acc_in    = uv_acc_ff;
      stall_acc_in = stall_acc_ff;
      spd_acc_in   = spd_acc_ff;
      if (!s1_run_ff) begin
         uv_acc_in    = '0;
         stall_acc_in = '0;
         spd_acc_in   = '0;
      end else begin
         // An invalid sample holds the run-mode accumulators but the held
         // values are still checked against their limits.
         if (enable_mask_ff[EN_UV]) begin
            if (!s1_inv_ff && uv_below) begin
               uv_acc_in = sat_add(uv_acc_ff, s1_dt_ff);
            end else if (!s1_inv_ff && uv_above) begin
               uv_acc_in = '0;
            end
            if (uv_acc_in >= {16'd0, uv_time_ff}) begin
               out_fault_in[FB_UV] = 1'b1;
            end
         end
         if (enable_mask_ff[EN_STALL]) begin
            if (!s1_inv_ff) begin
               stall_acc_in = stall_cond ? sat_add(stall_acc_ff, s1_dt_ff) : '0;
            end
            if (stall_acc_in >= {16'd0, stall_time_ff}) begin
               out_fault_in[FB_STALL] = 1'b1;
            end
         end
         if (enable_mask_ff[EN_SPD]) begin
            if (!s1_inv_ff) begin
               spd_acc_in = spd_cond ? sat_add(spd_acc_ff, s1_dt_ff) : '0;
            end
            if (spd_acc_in >= {16'd0, spd_err_time_ff}) begin
               out_fault_in[FB_SPD] = 1'b1;
            end
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff  <= RST_ENABLE_MASK;
         uv_level_ff     <= RST_UV_LEVEL_MV;
         uv_time_ff      <= RST_UV_TIME_MS;
         stall_cur_ff    <= RST_STALL_CURRENT_MA;
         stall_spd_ff    <= RST_STALL_SPEED_MRPS;
         stall_time_ff   <= RST_STALL_TIME_MS;
         spd_err_ff      <= RST_SPD_ERR_MRPS;
         spd_err_time_ff <= RST_SPD_ERR_TIME_MS;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENABLE_MASK:      enable_mask_ff  <= csr_data[MASK_W-1:0];
            CSR_UV_LEVEL_MV:      uv_level_ff     <= csr_data[15:0];
            CSR_UV_TIME_MS:       uv_time_ff      <= csr_data[15:0];
            CSR_STALL_CURRENT_MA: stall_cur_ff    <= csr_data[15:0];
            CSR_STALL_SPEED_MRPS: stall_spd_ff    <= csr_data[23:0];
            CSR_STALL_TIME_MS:    stall_time_ff   <= csr_data[15:0];
            CSR_SPD_ERR_MRPS:     spd_err_ff      <= csr_data[23:0];
            CSR_SPD_ERR_TIME_MS:  spd_err_time_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Stage valids, accumulators and sequence tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         comm_idle_ff <= '0;
         last_rx_ff   <= '0;
         uv_acc_ff    <= '0;
         stall_acc_ff <= '0;
         spd_acc_ff   <= '0;
      end else begin
         if (req_fire) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_vld_ff   <= 1'b1;
            comm_idle_ff <= comm_idle_in;
            last_rx_ff   <= last_rx_in;
            uv_acc_ff    <= uv_acc_in;
            stall_acc_ff <= stall_acc_in;
            spd_acc_ff   <= spd_acc_in;
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cur_a_ff  <= req_chan.current_a;
         s1_cur_b_ff  <= req_chan.current_b;
         s1_cur_c_ff  <= req_chan.current_c;
         s1_bus_ff    <= req_chan.bus_mv;
         s1_speed_ff  <= req_chan.speed_mrps;
         s1_target_ff <= req_chan.target_mrps;
         s1_seq_ff    <= req_chan.rx_seq;
         s1_run_ff    <= req_chan.is_run;
         s1_dt_ff     <= req_chan.delta_ms;
         s1_inv_ff    <= req_chan.sample_invalid;
      end
      if (s1_adv) begin
         out_fault_ff <= out_fault_in;
      end
   end

endmodule

// File: design/msfq_checker.sv
// Port-level checker for the slow-tick fault qualifier and its bind statement.
// Depends on msfq_pkg and motor_slow_fault_qualifier_core_macros.svh.
`include "motor_slow_fault_qualifier_core_macros.svh"

module msfq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [msfq_pkg::FAULT_W-1:0] fault_bits
);
   import msfq_pkg::*;

   logic req_accept;
   assign req_accept = req_valid && req_ready;

   // A stalled result transaction keeps its fault bits.
   `MSFQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(fault_bits))

   // When the result side can move, the sample side must be open.
   `MSFQ_ASSERT_IMPLY(a_ready_when_drain, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // A result that appears from an empty output came from a sample accepted through the sample register.
   `MSFQ_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_accept, 2))

endmodule

bind motor_slow_fault_qualifier_core msfq_checker u_msfq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .fault_bits (rsp_chan.fault_bits)
);
